/* src/aabb_axis_move_resolver_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the AABB move resolver
// Implication checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef AABB_AXIS_MOVE_RESOLVER_UNIT_ASSERT_SVH
`define AABB_AXIS_MOVE_RESOLVER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define AAMR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define AAMR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define AAMR_ASSERT_IMP(lbl, ante, cons)
`define AAMR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* src/aamr_pkg.sv */
// ----------------------------------------------------------------------------
// aamr_pkg
// Shared types, sizes and helpers of the AABB move resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package aamr_pkg;

	localparam int MAX_COLLIDERS = 64;
	localparam int ADDR_W        = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;
	localparam int CNT_W         = $clog2(MAX_COLLIDERS + 2);
	localparam int COORD_W       = 32;
	localparam int EXT_W         = COORD_W + 2;
	localparam int SLOT_W        = 6;

	localparam int S_TDATA_W = 200;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 64;
	localparam int M_TUSER_W = 3;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [EXT_W-1:0]   ext_t;

	typedef struct packed {
		coord_t hi_y;
		coord_t hi_x;
		coord_t lo_y;
		coord_t lo_x;
	} box_t;

	localparam int BOX_W = $bits(box_t);

	// one axis pass: mover span on the moving axis (alo..ahi), on the other (plo..phi)
	typedef struct packed {
		ext_t alo;
		ext_t ahi;
		ext_t plo;
		ext_t phi;
		ext_t d;
		logic vert;
	} axis_cfg_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic live;
	} scan_ctl_t;

	typedef struct packed {
		coord_t safe;
		logic   hit_pos;
		logic   hit_neg;
	} axis_res_t;

	function automatic ext_t sext(input coord_t v);
		return {{(EXT_W-COORD_W){v[COORD_W-1]}}, v};
	endfunction

endpackage

`default_nettype wire

/* src/aamr_ram.sv */
// ----------------------------------------------------------------------------
// aamr_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module aamr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* src/aamr_axis_unit.sv */
// ----------------------------------------------------------------------------
// aamr_axis_unit
// One axis pass: tests each table word against the swept mover and clamps
// the move to the nearest gap. Two stages: test, then accumulate.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aabb_axis_move_resolver_unit_assert.svh"

module aamr_axis_unit
	import aamr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire scan_ctl_t ctl,
	input  wire axis_cfg_t cfg_in,
	input  wire box_t      entry,
	output axis_res_t      res
);

	axis_cfg_t cfg_q;
	ext_t      sw_lo_q;
	ext_t      sw_hi_q;
	ext_t      safe_q;
	logic      hit_pos_q;
	logic      hit_neg_q;
	logic      v_s1;
	logic      cand_s2;
	ext_t      gap_s2;

	logic d_pos;
	logic d_neg;
	logic in_d_pos;
	logic in_d_neg;
	ext_t s_alo, s_ahi, s_plo, s_phi;
	logic box_ok, broad_ok, strict_ok, cand;
	ext_t gap;

	assign d_neg    = cfg_q.d[EXT_W-1];
	assign d_pos    = !cfg_q.d[EXT_W-1] && (cfg_q.d != '0);
	assign in_d_neg = cfg_in.d[EXT_W-1];
	assign in_d_pos = !cfg_in.d[EXT_W-1] && (cfg_in.d != '0);

	// stage 1: test the word just read
	always_comb begin
		box_ok = (entry.lo_x <= entry.hi_x) && (entry.lo_y <= entry.hi_y);
		if (cfg_q.vert) begin
			s_alo = sext(entry.lo_y);
			s_ahi = sext(entry.hi_y);
			s_plo = sext(entry.lo_x);
			s_phi = sext(entry.hi_x);
		end else begin
			s_alo = sext(entry.lo_x);
			s_ahi = sext(entry.hi_x);
			s_plo = sext(entry.lo_y);
			s_phi = sext(entry.hi_y);
		end
		broad_ok  = !((s_alo > sw_hi_q) || (s_ahi < sw_lo_q) ||
			(s_plo > cfg_q.phi) || (s_phi < cfg_q.plo));
		strict_ok = !((cfg_q.phi <= s_plo) || (cfg_q.plo >= s_phi));
		cand      = v_s1 && box_ok && broad_ok && strict_ok && (d_pos || d_neg);
		gap       = d_pos ? (s_alo - cfg_q.ahi) : (s_ahi - cfg_q.alo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q     <= '0;
			sw_lo_q   <= '0;
			sw_hi_q   <= '0;
			safe_q    <= '0;
			hit_pos_q <= 1'b0;
			hit_neg_q <= 1'b0;
			v_s1      <= 1'b0;
			cand_s2   <= 1'b0;
		end else begin
			v_s1    <= ctl.issue && ctl.live;
			cand_s2 <= cand;
			if (ctl.start) begin
				cfg_q     <= cfg_in;
				sw_lo_q   <= in_d_neg ? (cfg_in.alo + cfg_in.d) : cfg_in.alo;
				sw_hi_q   <= in_d_pos ? (cfg_in.ahi + cfg_in.d) : cfg_in.ahi;
				safe_q    <= cfg_in.d;
				hit_pos_q <= 1'b0;
				hit_neg_q <= 1'b0;
			end else if (cand_s2) begin
				// stage 2: clamp to the nearest gap, never past zero
				if (d_pos && (gap_s2 < safe_q)) begin
					safe_q    <= gap_s2[EXT_W-1] ? '0 : gap_s2;
					hit_pos_q <= 1'b1;
				end else if (d_neg && (gap_s2 > safe_q)) begin
					safe_q    <= gap_s2[EXT_W-1] ? gap_s2 : '0;
					hit_neg_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		gap_s2 <= gap;
	end

	assign res.safe    = safe_q[COORD_W-1:0];
	assign res.hit_pos = hit_pos_q;
	assign res.hit_neg = hit_neg_q;

	`AAMR_ASSERT_IMP(a_hit_one_side, hit_pos_q || hit_neg_q, !(hit_pos_q && hit_neg_q))
	`AAMR_ASSERT_IMP(a_safe_in_pos, d_pos, !safe_q[EXT_W-1] && (safe_q <= cfg_q.d))
	`AAMR_ASSERT_IMP(a_safe_in_neg, d_neg,
		(safe_q[EXT_W-1] || (safe_q == '0)) && (safe_q >= cfg_q.d))

endmodule

`default_nettype wire

/* src/aabb_axis_move_resolver_unit.sv */
// ----------------------------------------------------------------------------
// aabb_axis_move_resolver_unit
// Collider table with an axis-separated AABB move resolver.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tuser carries the command (write slot, clear slot,
// move query); s_axis_tdata carries slot, box edges and the desired move.
// Write and clear give no output word. A move query gives
// exactly one output word: resolved dx, dy and the floor, ceiling, wall hits.
// A query sweeps the collider RAM once per axis: a setup state, then a scan
// state with one read per cycle feeding the two-stage test and accumulate
// pipeline. The single RAM read port sets that one-read-per-cycle pace.
// One item is worked on at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so a new item is taken while it
// waits; a finished query holds in its last state until that register frees.
// Reset clears every live mark and empties the pipeline and output register;
// no clearing pass is needed, the table is usable straight after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aabb_axis_move_resolver_unit_assert.svh"

module aabb_axis_move_resolver_unit
	import aamr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// slot, box_min_x, box_min_y, box_max_x, box_max_y, delta_x, delta_y, pad
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
	// cmd
	input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// resolved_dx, resolved_dy
	output logic      [M_TDATA_W-1:0] m_axis_tdata,
	// hit_floor, hit_ceiling, hit_wall
	output logic      [M_TUSER_W-1:0] m_axis_tuser
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SETUP_X = 6'b000010,
		ST_SCAN_X  = 6'b000100,
		ST_SETUP_Y = 6'b001000,
		ST_SCAN_Y  = 6'b010000,
		ST_FINISH  = 6'b100000
	} state_t;

	localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(MAX_COLLIDERS + 1);
	localparam logic [CNT_W-1:0] SCAN_RD   = CNT_W'(MAX_COLLIDERS);

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAX_COLLIDERS-1:0] live_q;
	coord_t bx0_q, by0_q, bx1_q, by1_q, dx_q, dy_q, sx_q;
	logic wall_q;
	logic m_valid_q;
	coord_t out_dx_q, out_dy_q;
	logic out_floor_q, out_ceil_q, out_wall_q;

	cmd_t in_cmd;
	logic [SLOT_W-1:0] in_slot;
	box_t in_box;
	coord_t in_dx, in_dy;
	logic in_acc, slot_ok, ram_we, scanning, out_free;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	box_t rd_box;
	logic [BOX_W-1:0] rd_word;
	scan_ctl_t ctl;
	axis_cfg_t cfg;
	axis_res_t res;

	assign in_cmd       = cmd_t'(s_axis_tuser);
	assign in_slot      = s_axis_tdata[5:0];
	assign in_box.lo_x  = s_axis_tdata[37:6];
	assign in_box.lo_y  = s_axis_tdata[69:38];
	assign in_box.hi_x  = s_axis_tdata[101:70];
	assign in_box.hi_y  = s_axis_tdata[133:102];
	assign in_dx        = s_axis_tdata[165:134];
	assign in_dy        = s_axis_tdata[197:166];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign slot_ok       = (int'(in_slot) < MAX_COLLIDERS);
	assign wr_addr       = ADDR_W'(in_slot);
	assign ram_we        = in_acc && (in_cmd == CMD_WRITE) && slot_ok;

	assign scanning = (state_q == ST_SCAN_X) || (state_q == ST_SCAN_Y);
	assign rd_addr  = cnt_q[ADDR_W-1:0];
	assign out_free = !m_valid_q || m_axis_tready;

	aamr_ram #(
		.WIDTH (BOX_W),
		.DEPTH (MAX_COLLIDERS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (in_box),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	assign rd_box = box_t'(rd_word);

	always_comb begin
		ctl.start = (state_q == ST_SETUP_X) || (state_q == ST_SETUP_Y);
		ctl.issue = scanning && (cnt_q < SCAN_RD);
		ctl.live  = live_q[rd_addr];
		if (state_q == ST_SETUP_Y) begin
			cfg.alo  = sext(by0_q);
			cfg.ahi  = sext(by1_q);
			// mover shifted by the safe X move, never wrapped
			cfg.plo  = sext(bx0_q) + sext(res.safe);
			cfg.phi  = sext(bx1_q) + sext(res.safe);
			cfg.d    = sext(dy_q);
			cfg.vert = 1'b1;
		end else begin
			cfg.alo  = sext(bx0_q);
			cfg.ahi  = sext(bx1_q);
			cfg.plo  = sext(by0_q);
			cfg.phi  = sext(by1_q);
			cfg.d    = sext(dx_q);
			cfg.vert = 1'b0;
		end
	end

	aamr_axis_unit u_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cfg_in (cfg),
		.entry  (rd_box),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			live_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FINISH) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_cmd == CMD_WRITE && slot_ok) begin
							live_q[wr_addr] <= 1'b1;
						end else if (in_cmd == CMD_CLEAR && slot_ok) begin
							live_q[wr_addr] <= 1'b0;
						end else if (in_cmd == CMD_QUERY) begin
							state_q <= ST_SETUP_X;
						end
					end
				end
				ST_SETUP_X: begin
					cnt_q   <= '0;
					state_q <= ST_SCAN_X;
				end
				ST_SCAN_X: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SCAN_LAST) begin
						state_q <= ST_SETUP_Y;
					end
				end
				ST_SETUP_Y: begin
					cnt_q   <= '0;
					state_q <= ST_SCAN_Y;
				end
				ST_SCAN_Y: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SCAN_LAST) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// hold until the output register frees
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (in_cmd == CMD_QUERY)) begin
			bx0_q <= in_box.lo_x;
			by0_q <= in_box.lo_y;
			bx1_q <= in_box.hi_x;
			by1_q <= in_box.hi_y;
			dx_q  <= in_dx;
			dy_q  <= in_dy;
		end
		if (state_q == ST_SETUP_Y) begin
			sx_q   <= res.safe;
			wall_q <= res.hit_pos || res.hit_neg;
		end
		if ((state_q == ST_FINISH) && out_free) begin
			out_dx_q    <= sx_q;
			out_dy_q    <= res.safe;
			out_floor_q <= res.hit_neg;
			out_ceil_q  <= res.hit_pos;
			out_wall_q  <= wall_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {out_dy_q, out_dx_q};
	assign m_axis_tuser  = {out_wall_q, out_ceil_q, out_floor_q};

	`AAMR_ASSERT_IMP(a_out_from_finish, $rose(m_axis_tvalid), $past(state_q == ST_FINISH))
	`AAMR_ASSERT_IMP(a_full_x_scan, state_q == ST_SETUP_Y, $past(cnt_q) == SCAN_LAST)
	`AAMR_ASSERT_NXT(a_query_starts, in_acc && (in_cmd == CMD_QUERY), state_q == ST_SETUP_X)

endmodule

`default_nettype wire
